### hw/rtl/cvmb_pkg.sv
// Shared types and constants for the camera view matrix builder.
// No dependencies; every other file of the block imports this package.
package cvmb_pkg;

	// Fraction bits of the Q2.14 direction vectors.
	localparam int FRAC_BITS = 14;

	typedef struct packed {
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] fwd_x;
		logic signed [15:0] fwd_y;
		logic signed [15:0] fwd_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} pose_t;

	typedef struct packed {
		logic signed [15:0] out_right_x;
		logic signed [15:0] out_right_y;
		logic signed [15:0] out_right_z;
		logic signed [15:0] out_up_x;
		logic signed [15:0] out_up_y;
		logic signed [15:0] out_up_z;
		logic signed [15:0] out_fwd_x;
		logic signed [15:0] out_fwd_y;
		logic signed [15:0] out_fwd_z;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
	} view_t;

endpackage

### hw/rtl/cvmb_norm.sv
// Pipelined normalizer for a three component vector: squares, sum, a bit-per-stage
// square root and a bit-per-stage rounded divide for each lane. Uses cvmb_pkg.
// A sideband word travels alongside so the caller can keep other data in step.
module cvmb_norm
	import cvmb_pkg::*;
#(
	parameter int CW = 32,
	parameter int SW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [2:0][CW-1:0]   c,
	input  logic [SW-1:0]        in_side,
	output logic                 out_valid,
	output logic [2:0][15:0]     o,
	output logic [SW-1:0]        out_side
);
	localparam int LW = 2 * CW;
	localparam int NI = CW;
	localparam int QB = FRAC_BITS + 1;
	localparam int DW = CW + QB;

	logic                 v_s1, v_s2, v_s3;
	logic [2:0]           sgn_s1, sgn_s2, sgn_s3;
	logic [2:0][CW-1:0]   mag_s1, mag_s2, mag_s3;
	logic [SW-1:0]        side_s1, side_s2, side_s3;
	logic [2:0][LW-1:0]   sq_s2;
	logic                 zero_s2, zero_s3;
	logic [LW-1:0]        len_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sgn_s1[i] <= c[i][CW-1];
			mag_s1[i] <= c[i][CW-1] ? (~c[i] + 1'b1) : c[i];
			sq_s2[i]  <= LW'(mag_s1[i]) * LW'(mag_s1[i]);
		end
		side_s1 <= in_side;
		sgn_s2  <= sgn_s1;
		mag_s2  <= mag_s1;
		side_s2 <= side_s1;
		zero_s2 <= (mag_s1 == '0);
		len_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		sgn_s3  <= sgn_s2;
		mag_s3  <= mag_s2;
		side_s3 <= side_s2;
		zero_s3 <= zero_s2;
	end

	// Square root, one result bit per stage.
	logic [NI:0]          rt_v_s;
	logic [LW-1:0]        rt_n_s    [NI+1];
	logic [LW-1:0]        rt_r_s    [NI+1];
	logic [2:0][CW-1:0]   rt_mag_s  [NI+1];
	logic [2:0]           rt_sgn_s  [NI+1];
	logic [NI:0]          rt_zero_s;
	logic [SW-1:0]        rt_side_s [NI+1];

	assign rt_v_s[0]    = v_s3;
	assign rt_n_s[0]    = len_s3;
	assign rt_r_s[0]    = '0;
	assign rt_mag_s[0]  = mag_s3;
	assign rt_sgn_s[0]  = sgn_s3;
	assign rt_zero_s[0] = zero_s3;
	assign rt_side_s[0] = side_s3;

	for (genvar k = 0; k < NI; k++) begin : g_root
		localparam int SH = LW - 2 - 2 * k;
		logic [LW-1:0] bitv, trial;
		assign bitv  = {{(LW-1){1'b0}}, 1'b1} << SH;
		assign trial = rt_r_s[k] + bitv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[k+1] <= 1'b0;
			end else begin
				rt_v_s[k+1] <= rt_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rt_n_s[k] >= trial) begin
				rt_n_s[k+1] <= rt_n_s[k] - trial;
				rt_r_s[k+1] <= (rt_r_s[k] >> 1) + bitv;
			end else begin
				rt_n_s[k+1] <= rt_n_s[k];
				rt_r_s[k+1] <= rt_r_s[k] >> 1;
			end
			rt_mag_s[k+1]  <= rt_mag_s[k];
			rt_sgn_s[k+1]  <= rt_sgn_s[k];
			rt_zero_s[k+1] <= rt_zero_s[k];
			rt_side_s[k+1] <= rt_side_s[k];
		end
	end

	// Rounded divide of each magnitude by the root, one quotient bit per stage.
	logic [QB:0]           dv_v_s;
	logic [2:0][DW-1:0]    dv_rem_s  [QB+1];
	logic [2:0][QB-1:0]    dv_q_s    [QB+1];
	logic [CW-1:0]         dv_d_s    [QB+1];
	logic [2:0]            dv_sgn_s  [QB+1];
	logic [QB:0]           dv_zero_s;
	logic [SW-1:0]         dv_side_s [QB+1];
	logic [CW-1:0]         root;

	assign root = rt_r_s[NI][CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= rt_v_s[NI];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[0][i] <= (DW'(rt_mag_s[NI][i]) << FRAC_BITS) + DW'(root >> 1);
		end
		dv_q_s[0]    <= '0;
		dv_d_s[0]    <= root;
		dv_sgn_s[0]  <= rt_sgn_s[NI];
		dv_zero_s[0] <= rt_zero_s[NI];
		dv_side_s[0] <= rt_side_s[NI];
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int KB = QB - 1 - j;
		logic [DW-1:0] dsh;
		assign dsh = DW'(dv_d_s[j]) << KB;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_rem_s[j][i] >= dsh) begin
					dv_rem_s[j+1][i] <= dv_rem_s[j][i] - dsh;
					dv_q_s[j+1][i]   <= dv_q_s[j][i] | ({{(QB-1){1'b0}}, 1'b1} << KB);
				end else begin
					dv_rem_s[j+1][i] <= dv_rem_s[j][i];
					dv_q_s[j+1][i]   <= dv_q_s[j][i];
				end
			end
			dv_d_s[j+1]    <= dv_d_s[j];
			dv_sgn_s[j+1]  <= dv_sgn_s[j];
			dv_zero_s[j+1] <= dv_zero_s[j];
			dv_side_s[j+1] <= dv_side_s[j];
		end
	end

	// The quotient never exceeds one in Q2.14, so no clamp is needed.
	logic                 fin_v_s;
	logic [2:0][15:0]     fin_o_s;
	logic [SW-1:0]        fin_side_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_v_s <= 1'b0;
		end else begin
			fin_v_s <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (dv_zero_s[QB]) begin
				fin_o_s[i] <= '0;
			end else if (dv_sgn_s[QB][i]) begin
				fin_o_s[i] <= 16'(-(16'(dv_q_s[QB][i])));
			end else begin
				fin_o_s[i] <= 16'(dv_q_s[QB][i]);
			end
		end
		fin_side_s <= dv_side_s[QB];
	end

	assign out_valid = fin_v_s;
	assign o         = fin_o_s;
	assign out_side  = fin_side_s;
endmodule

### hw/rtl/cvmb_cross.sv
// Two stage cross product of two Q2.14 vectors: products, then differences.
// Uses cvmb_pkg; carries a sideband word in step with the data.
module cvmb_cross
	import cvmb_pkg::*;
#(
	parameter int SW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2:0][15:0]  a,
	input  logic [2:0][15:0]  b,
	input  logic [SW-1:0]     in_side,
	output logic              out_valid,
	output logic [2:0][31:0]  o,
	output logic [SW-1:0]     out_side
);
	logic                v_s1, v_s2;
	logic signed [31:0]  prod_s1 [6];
	logic [2:0][31:0]    o_s2;
	logic [SW-1:0]       side_s1, side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// The first operand is always a unit vector, at most one in Q2.14, and the
	// second at most two, so each difference fits in 32 bits.
	always_ff @(posedge clk) begin
		prod_s1[0] <= $signed(a[1]) * $signed(b[2]);
		prod_s1[1] <= $signed(a[2]) * $signed(b[1]);
		prod_s1[2] <= $signed(a[2]) * $signed(b[0]);
		prod_s1[3] <= $signed(a[0]) * $signed(b[2]);
		prod_s1[4] <= $signed(a[0]) * $signed(b[1]);
		prod_s1[5] <= $signed(a[1]) * $signed(b[0]);
		side_s1    <= in_side;
		o_s2[0]    <= 32'(prod_s1[0] - prod_s1[1]);
		o_s2[1]    <= 32'(prod_s1[2] - prod_s1[3]);
		o_s2[2]    <= 32'(prod_s1[4] - prod_s1[5]);
		side_s2    <= side_s1;
	end

	assign out_valid = v_s2;
	assign o         = o_s2;
	assign out_side  = side_s2;
endmodule

### hw/rtl/cvmb_trans.sv
// Final stages: rounds the corrected right vector, forms the three position
// dot products, negates, rounds and saturates them, and registers the result word.
// Uses cvmb_pkg.
module cvmb_trans
	import cvmb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2:0][31:0]  rc,
	input  logic [2:0][15:0]  un,
	input  logic [2:0][15:0]  fn,
	input  logic [2:0][31:0]  pos,
	output logic              done,
	output view_t             result
);
	function automatic logic [15:0] round_sat16(input logic signed [31:0] v);
		logic [31:0] m;
		logic [18:0] q;
		m = v[31] ? (~v + 1'b1) : v;
		q = 19'((m + 32'd8192) >> FRAC_BITS);
		if (v[31]) begin
			round_sat16 = (q > 19'd32768) ? 16'h8000 : 16'(-q);
		end else begin
			round_sat16 = (q > 19'd32767) ? 16'h7fff : 16'(q);
		end
	endfunction

	// Negated sum rounded to Q16.16 with ties away from zero, then saturated.
	function automatic logic [31:0] neg_round_sat32(input logic signed [49:0] d);
		logic [49:0] m;
		logic [35:0] q;
		m = d[49] ? (~d + 1'b1) : d;
		q = 36'((m + 50'd8192) >> FRAC_BITS);
		if (d[49]) begin
			neg_round_sat32 = (q > 36'h07fffffff) ? 32'h7fffffff : 32'(q);
		end else begin
			neg_round_sat32 = (q > 36'h080000000) ? 32'h80000000 : 32'(-q);
		end
	endfunction

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [2:0][15:0]    rn_s1, rn_s2, rn_s3;
	logic [2:0][15:0]    un_s1, un_s2, un_s3;
	logic [2:0][15:0]    fn_s1, fn_s2, fn_s3;
	logic [2:0][31:0]    pos_s1;
	logic signed [47:0]  prod_s2 [3][3];
	logic signed [49:0]  dot_s3 [3];
	view_t               res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rn_s1[i] <= round_sat16($signed(rc[i]));
			prod_s2[0][i] <= $signed(pos_s1[i]) * $signed(rn_s1[i]);
			prod_s2[1][i] <= $signed(pos_s1[i]) * $signed(un_s1[i]);
			prod_s2[2][i] <= $signed(pos_s1[i]) * $signed(fn_s1[i]);
			dot_s3[i] <= 50'(prod_s2[i][0]) + 50'(prod_s2[i][1]) + 50'(prod_s2[i][2]);
		end
		un_s1  <= un;
		fn_s1  <= fn;
		pos_s1 <= pos;
		rn_s2  <= rn_s1;
		un_s2  <= un_s1;
		fn_s2  <= fn_s1;
		rn_s3  <= rn_s2;
		un_s3  <= un_s2;
		fn_s3  <= fn_s2;

		res_s4.out_right_x <= rn_s3[0];
		res_s4.out_right_y <= rn_s3[1];
		res_s4.out_right_z <= rn_s3[2];
		res_s4.out_up_x    <= un_s3[0];
		res_s4.out_up_y    <= un_s3[1];
		res_s4.out_up_z    <= un_s3[2];
		res_s4.out_fwd_x   <= fn_s3[0];
		res_s4.out_fwd_y   <= fn_s3[1];
		res_s4.out_fwd_z   <= fn_s3[2];
		res_s4.trans_x     <= neg_round_sat32(dot_s3[0]);
		res_s4.trans_y     <= neg_round_sat32(dot_s3[1]);
		res_s4.trans_z     <= neg_round_sat32(dot_s3[2]);
	end

	assign done   = v_s4;
	assign result = res_s4;
endmodule

### hw/rtl/camera_view_matrix_builder.sv
// Camera view matrix builder: takes one camera pose word per clock and returns
// the upper 4x3 part of the row-vector view matrix, one result word per pose,
// marked by done for a single cycle. Most of the pipeline's stages lie in the two
// normalizers, each a square root resolved one bit per stage (30 and 32 stages)
// followed by a 15 stage divide; throughput is one pose per cycle and busy is
// never raised. The receiver cannot stall, so a result must be taken the cycle
// it appears.
module camera_view_matrix_builder
	import cvmb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  pose_t  pose,
	output logic   done,
	output view_t  result
);
	logic [2:0][15:0]  rv;
	logic [2:0][29:0]  fc;
	logic [2:0][31:0]  posv;

	assign busy = 1'b0;
	assign rv   = {pose.right_z, pose.right_y, pose.right_x};
	assign fc   = {pose.fwd_z, 14'd0, pose.fwd_y, 14'd0, pose.fwd_x, 14'd0};
	assign posv = {pose.pos_z, pose.pos_y, pose.pos_x};

	// Forward normalization; right and position ride along.
	logic              n1_v;
	logic [2:0][15:0]  fn1;
	logic [143:0]      n1_side;

	cvmb_norm #(.CW(30), .SW(144)) u_norm_fwd (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.c(fc), .in_side({posv, rv}),
		.out_valid(n1_v), .o(fn1), .out_side(n1_side)
	);

	// Up direction before normalization: forward x right.
	logic              c1_v;
	logic [2:0][31:0]  uc;
	logic [143:0]      c1_side;

	cvmb_cross #(.SW(144)) u_cross_up (
		.clk(clk), .arst_n(arst_n), .in_valid(n1_v),
		.a(fn1), .b(n1_side[47:0]), .in_side({n1_side[143:48], fn1}),
		.out_valid(c1_v), .o(uc), .out_side(c1_side)
	);

	logic              n2_v;
	logic [2:0][15:0]  un2;
	logic [143:0]      n2_side;

	cvmb_norm #(.CW(32), .SW(144)) u_norm_up (
		.clk(clk), .arst_n(arst_n), .in_valid(c1_v),
		.c(uc), .in_side(c1_side),
		.out_valid(n2_v), .o(un2), .out_side(n2_side)
	);

	// Corrected right: up x forward.
	logic              c2_v;
	logic [2:0][31:0]  rc;
	logic [191:0]      c2_side;

	cvmb_cross #(.SW(192)) u_cross_right (
		.clk(clk), .arst_n(arst_n), .in_valid(n2_v),
		.a(un2), .b(n2_side[47:0]), .in_side({n2_side, un2}),
		.out_valid(c2_v), .o(rc), .out_side(c2_side)
	);

	cvmb_trans u_trans (
		.clk(clk), .arst_n(arst_n), .in_valid(c2_v),
		.rc(rc), .un(c2_side[47:0]), .fn(c2_side[95:48]), .pos(c2_side[191:96]),
		.done(done), .result(result)
	);
endmodule

### sim/tb.sv
// Testbench for camera_view_matrix_builder: directed poses from a table, then random poses.
// Every result word is checked against a behavioral predictor of the view matrix.
// Depends on cvmb_pkg and the block's RTL only.
module tb;
	import cvmb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 110;
	localparam int N_RANDOM = 830;
	localparam longint CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	pose_t pose = '0;
	view_t result;

	typedef struct {
		pose_t p;
		logic has_want;
		view_t want;
	} stim_row_t;

	view_t matrix_queue[$];
	int n_err = 0;
	int n_checked = 0;
	int n_sent = 0;
	int n_sat = 0;
	longint cycles = 0;
	int idle_pct = 0;

	camera_view_matrix_builder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pose(pose), .done(done), .result(result)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Scale a vector to unit length in Q2.14; a zero vector stays zero.
	function automatic void unit_vec(input longint c[3], output longint o[3]);
		longint unsigned len2, s, q;
		longint v;
		len2 = 0;
		for (int i = 0; i < 3; i++) len2 += abs64(c[i]) * abs64(c[i]);
		if (len2 == 0) begin
			o = '{0, 0, 0};
			return;
		end
		s = int_sqrt(len2);
		for (int i = 0; i < 3; i++) begin
			q = ((abs64(c[i]) << 14) + s / 2) / s;
			v = q > 32768 ? 32768 : longint'(q);
			v = c[i] < 0 ? -v : v;
			o[i] = v > 32767 ? 32767 : v;
		end
	endfunction

	function automatic void cross_prod(input longint a[3], input longint b[3],
			output longint o[3]);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic longint round_q14(longint v);
		longint unsigned m;
		m = (abs64(v) + (64'd1 << 13)) >> 14;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [31:0] neg_dot(longint p[3], longint v[3]);
		longint d;
		d = p[0] * v[0] + p[1] * v[1] + p[2] * v[2];
		return 32'(clamp(round_q14(-d), -64'sd2147483648, 64'sd2147483647));
	endfunction

	function automatic view_t view_of(pose_t ps);
		longint r[3], p[3], fc[3], fn[3], uc[3], un[3], rc[3], rn[3];
		view_t v;
		r = '{ps.right_x, ps.right_y, ps.right_z};
		p = '{ps.pos_x, ps.pos_y, ps.pos_z};
		fc = '{longint'(ps.fwd_x) * 16384, longint'(ps.fwd_y) * 16384,
			longint'(ps.fwd_z) * 16384};
		unit_vec(fc, fn);
		cross_prod(fn, r, uc);
		unit_vec(uc, un);
		cross_prod(un, fn, rc);
		for (int i = 0; i < 3; i++) rn[i] = clamp(round_q14(rc[i]), -32768, 32767);
		v.out_right_x = 16'(rn[0]); v.out_right_y = 16'(rn[1]); v.out_right_z = 16'(rn[2]);
		v.out_up_x = 16'(un[0]); v.out_up_y = 16'(un[1]); v.out_up_z = 16'(un[2]);
		v.out_fwd_x = 16'(fn[0]); v.out_fwd_y = 16'(fn[1]); v.out_fwd_z = 16'(fn[2]);
		v.trans_x = neg_dot(p, rn);
		v.trans_y = neg_dot(p, un);
		v.trans_z = neg_dot(p, fn);
		return v;
	endfunction

	// Compare each result word with the oldest pending matrix.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (matrix_queue.size() == 0) begin
				n_err++;
				if (n_err <= 10) $display("result word with nothing pending: %h", result);
			end else begin
				view_t w;
				w = matrix_queue.pop_front();
				n_checked++;
				if (w.trans_x == 32'h7fffffff || w.trans_x == 32'h80000000) n_sat++;
				if (result !== w) begin
					n_err++;
					if (n_err <= 10) begin
						$display("mismatch %0d: expected %h", n_checked, w);
						$display("             actual   %h", result);
					end
				end
			end
		end
	end

	task automatic send(pose_t ps);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pose <= ps;
		do @(posedge clk); while (busy);
		matrix_queue.push_back(view_of(ps));
		n_sent++;
	endtask

	function automatic logic signed [15:0] rnd16();
		case ($urandom_range(7))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(64)) - 32);
			3: return 0;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [31:0] rnd32();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 32'($urandom_range(2000000)) - 32'sd1000000;
			default: return $urandom;
		endcase
	endfunction

	function automatic pose_t rnd_pose();
		pose_t ps;
		ps.right_x = rnd16(); ps.right_y = rnd16(); ps.right_z = rnd16();
		ps.fwd_x = rnd16(); ps.fwd_y = rnd16(); ps.fwd_z = rnd16();
		// Sometimes make forward parallel to right.
		if ($urandom_range(15) == 0) begin
			ps.fwd_x = ps.right_x; ps.fwd_y = ps.right_y; ps.fwd_z = ps.right_z;
		end
		ps.pos_x = rnd32(); ps.pos_y = rnd32(); ps.pos_z = rnd32();
		return ps;
	endfunction

	function automatic pose_t mk(int rx, int ry, int rz, int fx, int fy, int fz,
			int px, int py, int pz);
		pose_t ps;
		ps = '{16'(rx), 16'(ry), 16'(rz), 16'(fx), 16'(fy), 16'(fz),
			32'(px), 32'(py), 32'(pz)};
		return ps;
	endfunction

	stim_row_t rows[$];
	view_t ident;

	initial begin
		// Identity camera at origin: right +x, forward +z gives up +y.
		ident = '0;
		ident.out_right_x = 16384; ident.out_up_y = 16384; ident.out_fwd_z = 16384;
		rows.push_back('{mk(16384, 0, 0, 0, 0, 16384, 0, 0, 0), 1'b1, ident});
		// Zero-length forward makes everything zero.
		rows.push_back('{mk(16384, 5, -7, 0, 0, 0, 123456, -9, 77), 1'b1, '0});
		rows.push_back('{mk(-32768, -32768, -32768, 0, 0, 0, -2147483648, -2147483648,
			-2147483648), 1'b1, '0});
		// Forward parallel to right, extremes of position, saturating translation.
		rows.push_back('{mk(100, 200, 300, 100, 200, 300, 2147483647, 0, 0), 1'b0, '0});
		rows.push_back('{mk(16384, 0, 0, 0, 0, 16384, 0, 0, 2147483647), 1'b0, '0});
		rows.push_back('{mk(16384, 0, 0, 0, 0, -32768, 0, 0, -2147483648), 1'b0, '0});
		rows.push_back('{mk(32767, 32767, 32767, -32768, 0, 0, 2147483647, 2147483647,
			2147483647), 1'b0, '0});
		rows.push_back('{mk(-32768, 32767, -32768, 32767, 32767, 32767, -2147483648,
			2147483647, -2147483648), 1'b0, '0});
		rows.push_back('{mk(-1, -1, -1, -1, -1, -1, -1, -1, -1), 1'b0, '0});
		rows.push_back('{mk(1, 0, 0, 0, 1, 0, 65536, 65536, 65536), 1'b0, '0});
		rows.push_back('{mk(0, 0, 0, 3, 4, 0, 1000, 2000, 3000), 1'b0, '0});
		rows.push_back('{mk(0, 16384, 0, 16384, 0, 0, -65536, 65536, 0), 1'b0, '0});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send(rows[i].p);
			if (rows[i].has_want && view_of(rows[i].p) !== rows[i].want) begin
				n_err++;
				$display("directed row %0d: typed-in matrix disagrees with predictor", i);
			end
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			case (i * 4 / N_RANDOM)
				0: idle_pct = 0;
				1: idle_pct = 54;
				2: idle_pct = 16;
				default: idle_pct = (i / 50) % 2 ? 54 : 0;
			endcase
			send(rnd_pose());
		end
		start <= 1'b0;
		while (matrix_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("sent %0d poses, checked %0d matrices, %0d with saturated trans_x",
			n_sent, n_checked, n_sat);
		if (n_err == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", n_err);
			$display("FAIL");
		end
		$finish;
	end
endmodule

### filelist.f
hw/rtl/cvmb_pkg.sv
hw/rtl/cvmb_norm.sv
hw/rtl/cvmb_cross.sv
hw/rtl/cvmb_trans.sv
hw/rtl/camera_view_matrix_builder.sv
sim/tb.sv
